// ===== sv/udprc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udprc_pkg: shared types and constants for the UDP receive checker
// Verdict codes, register map, configuration bundle and the
// ones-complement add used by the checksum datapath.
// ----------------------------------------------------------------------------
package udprc_pkg;

	localparam int OPEN_PORT_SLOTS  = 4;
	localparam int UDP_HEADER_BYTES = 8;
	localparam logic [15:0] PROTO_UDP = 16'd17;

	// Register word indexes (byte address = 4 * index)
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_LOCAL_IP  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PORT_A    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PORT_MASK = 3'd5;
	localparam int PADDR_W = REG_IDX_W + 2;

	typedef enum logic [1:0] {
		VERDICT_DELIVER     = 2'd0,
		VERDICT_BAD_LENGTH  = 2'd1,
		VERDICT_BAD_CSUM    = 2'd2,
		VERDICT_UNREACHABLE = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [31:0]                      local_ip;
		logic [OPEN_PORT_SLOTS-1:0][15:0] open_port;
		logic [OPEN_PORT_SLOTS-1:0]       port_mask;
	} cfg_t;

	// One ones-complement accumulate step with a single end-around fold
	function automatic logic [16:0] oc_add(input logic [16:0] s, input logic [15:0] w);
		logic [17:0] t;
		logic [16:0] r;
		t = {1'b0, s} + {2'b00, w};
		r = {1'b0, t[15:0]} + {15'd0, t[17:16]};
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/udprc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udprc_if: request channels of the UDP receive checker
// Byte channel into the checker and verdict channel out of it.
// ----------------------------------------------------------------------------
interface udprc_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic [31:0] sender_ip;

	modport source (output valid, data_byte, last_byte, sender_ip, input ready);
	modport sink   (input valid, data_byte, last_byte, sender_ip, output ready);
endinterface

interface udprc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  verdict;
	logic [15:0] destination_port;
	logic [15:0] source_port;
	logic [15:0] received_length;

	modport source (output valid, verdict, destination_port, source_port, received_length,
		input ready);
	modport sink   (input valid, verdict, destination_port, source_port, received_length,
		output ready);
endinterface
`default_nettype wire

// ===== sv/udprc_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udprc_regs: configuration register file
// APB-style write/read of local IP, open port slots and the enable mask.
// ----------------------------------------------------------------------------
module udprc_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [udprc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	output udprc_pkg::cfg_t                   cfg
);

	logic [udprc_pkg::REG_IDX_W-1:0] idx;
	logic                            wr_en;
	udprc_pkg::cfg_t                 cfg_q;

	assign idx    = paddr[udprc_pkg::PADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			if (idx == udprc_pkg::REG_LOCAL_IP) begin
				cfg_q.local_ip <= pwdata;
			end
			if (idx == udprc_pkg::REG_PORT_MASK) begin
				cfg_q.port_mask <= pwdata[udprc_pkg::OPEN_PORT_SLOTS-1:0];
			end
			for (int slot = 0; slot < udprc_pkg::OPEN_PORT_SLOTS; slot++) begin
				if (idx == udprc_pkg::REG_IDX_W'(udprc_pkg::REG_PORT_A + slot)) begin
					cfg_q.open_port[slot] <= pwdata[15:0];
				end
			end
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		if (idx == udprc_pkg::REG_LOCAL_IP) begin
			prdata = cfg_q.local_ip;
		end else if (idx == udprc_pkg::REG_PORT_MASK) begin
			prdata = 32'(cfg_q.port_mask);
		end
		for (int slot = 0; slot < udprc_pkg::OPEN_PORT_SLOTS; slot++) begin
			if (idx == udprc_pkg::REG_IDX_W'(udprc_pkg::REG_PORT_A + slot)) begin
				prdata = {16'd0, cfg_q.open_port[slot]};
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/udp_receive_checker_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The verdict is registered after the last byte passes the input and stage 2 registers.
// Throughput: one byte per cycle; a last byte waits in stage 1 while stage 2 is stalled.
// The final sum is split across two register stages (sender IP, then local IP,
// protocol and length) ahead of the verdict register.
// Reset: arst_n clears config, per-datagram state and pipeline valids; no clearing pass.
// ----------------------------------------------------------------------------
// udp_receive_checker_unit: UDP receive checksum, length and port checker
// Accumulates header fields and the ones-complement sum per byte and gives
// one verdict with both ports and the received length per datagram.
// ----------------------------------------------------------------------------
module udp_receive_checker_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	udprc_in_if.sink                           rx,
	udprc_out_if.source                        result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [udprc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);

	udprc_pkg::cfg_t cfg;

	udprc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Per-datagram state
	logic [15:0] byte_count_q;
	logic        length_overflow_q;
	logic [16:0] running_sum_q;
	logic [7:0]  pending_high_q;
	logic [15:0] hdr_src_q;
	logic [15:0] hdr_dst_q;
	logic [15:0] len_field_q;
	logic [15:0] csum_field_q;

	// Stage 1: registered input byte
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [31:0] sip_s1;

	// Stage 2: snapshot of a finished datagram, partial sum
	logic        valid_s2;
	logic [16:0] psum_s2;
	logic [15:0] count_s2;
	logic        ovf_s2;
	logic [15:0] src_s2;
	logic [15:0] dst_s2;
	logic [15:0] len_s2;
	logic [15:0] csum_s2;

	// Result register
	logic        res_valid_q;
	logic [1:0]  res_verdict_q;
	logic [15:0] res_dst_q;
	logic [15:0] res_src_q;
	logic [15:0] res_len_q;

	// Flow control
	logic out_adv, s2_free, s2_move, s1_move;

	assign out_adv  = !res_valid_q || result.ready;
	assign s2_move  = valid_s2 && out_adv;
	assign s2_free  = !valid_s2 || out_adv;
	assign s1_move  = valid_s1 && (!last_s1 || s2_free);
	assign rx.ready = !valid_s1 || s1_move;

	// Stage 1: per-byte state update and first half of the final sum
	logic [15:0] cnt_n;
	logic        ovf_n;
	logic [16:0] sum_n;
	logic [7:0]  pend_n;
	logic [15:0] src_n, dst_n, len_n, csum_n;
	logic [16:0] psum_n;

	always_comb begin
		logic [15:0] w;
		logic [16:0] s;
		cnt_n  = byte_count_q;
		ovf_n  = length_overflow_q;
		sum_n  = running_sum_q;
		pend_n = pending_high_q;
		src_n  = hdr_src_q;
		dst_n  = hdr_dst_q;
		len_n  = len_field_q;
		csum_n = csum_field_q;
		w      = {pending_high_q, byte_s1};
		if (byte_count_q == 16'hFFFF) begin
			ovf_n = 1'b1;
		end else if (!length_overflow_q) begin
			if (!byte_count_q[0]) begin
				pend_n = byte_s1;
			end else begin
				unique case (byte_count_q)
					16'd1:   src_n  = w;
					16'd3:   dst_n  = w;
					16'd5:   len_n  = w;
					16'd7:   csum_n = w;
					default: ;
				endcase
				// checksum field itself is summed as zero
				if (byte_count_q != 16'd7) begin
					sum_n = udprc_pkg::oc_add(running_sum_q, w);
				end
			end
			cnt_n = byte_count_q + 16'd1;
		end
		// odd tail padded with zero, then sender IP of the pseudo header
		s = sum_n;
		if (!ovf_n && cnt_n[0]) begin
			s = udprc_pkg::oc_add(s, {pend_n, 8'h00});
		end
		s      = udprc_pkg::oc_add(s, sip_s1[31:16]);
		psum_n = udprc_pkg::oc_add(s, sip_s1[15:0]);
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.data_byte;
			last_s1 <= rx.last_byte;
			sip_s1  <= rx.sender_ip;
		end
	end

	// Datagram state: updated as each byte leaves stage 1, cleared after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q      <= '0;
			length_overflow_q <= 1'b0;
			running_sum_q     <= '0;
			pending_high_q    <= '0;
			hdr_src_q         <= '0;
			hdr_dst_q         <= '0;
			len_field_q       <= '0;
			csum_field_q      <= '0;
		end else if (s1_move) begin
			if (last_s1) begin
				byte_count_q      <= '0;
				length_overflow_q <= 1'b0;
				running_sum_q     <= '0;
				pending_high_q    <= '0;
				hdr_src_q         <= '0;
				hdr_dst_q         <= '0;
				len_field_q       <= '0;
				csum_field_q      <= '0;
			end else begin
				byte_count_q      <= cnt_n;
				length_overflow_q <= ovf_n;
				running_sum_q     <= sum_n;
				pending_high_q    <= pend_n;
				hdr_src_q         <= src_n;
				hdr_dst_q         <= dst_n;
				len_field_q       <= len_n;
				csum_field_q      <= csum_n;
			end
		end
	end

	// Stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_move && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && last_s1) begin
			psum_s2  <= psum_n;
			count_s2 <= cnt_n;
			ovf_s2   <= ovf_n;
			src_s2   <= src_n;
			dst_s2   <= dst_n;
			len_s2   <= len_n;
			csum_s2  <= csum_n;
		end
	end

	// Stage 2: rest of the pseudo header, checks and verdict
	udprc_pkg::verdict_t verdict_n;

	always_comb begin
		logic [16:0] s;
		logic [15:0] calc;
		logic        port_hit;
		s    = udprc_pkg::oc_add(psum_s2, cfg.local_ip[31:16]);
		s    = udprc_pkg::oc_add(s, cfg.local_ip[15:0]);
		s    = udprc_pkg::oc_add(s, udprc_pkg::PROTO_UDP);
		s    = udprc_pkg::oc_add(s, count_s2);
		calc = ~s[15:0];
		// a zero complement is sent as all ones
		if (calc == 16'd0) begin
			calc = 16'hFFFF;
		end
		port_hit = 1'b0;
		for (int i = 0; i < udprc_pkg::OPEN_PORT_SLOTS; i++) begin
			if (cfg.port_mask[i] && (cfg.open_port[i] == dst_s2)) begin
				port_hit = 1'b1;
			end
		end
		priority if (ovf_s2 || (count_s2 < 16'(udprc_pkg::UDP_HEADER_BYTES))
				|| (count_s2 < len_s2)) begin
			verdict_n = udprc_pkg::VERDICT_BAD_LENGTH;
		end else if ((csum_s2 != 16'd0) && (calc != csum_s2)) begin
			// zero received checksum means none was computed
			verdict_n = udprc_pkg::VERDICT_BAD_CSUM;
		end else if (!port_hit) begin
			verdict_n = udprc_pkg::VERDICT_UNREACHABLE;
		end else begin
			verdict_n = udprc_pkg::VERDICT_DELIVER;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_adv) begin
			res_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			res_verdict_q <= verdict_n;
			res_dst_q     <= dst_s2;
			res_src_q     <= src_s2;
			res_len_q     <= count_s2;
		end
	end

	assign result.valid            = res_valid_q;
	assign result.verdict          = res_verdict_q;
	assign result.destination_port = res_dst_q;
	assign result.source_port      = res_src_q;
	assign result.received_length  = res_len_q;

`ifndef SYNTHESIS
	// state is cleared once a datagram's last byte leaves stage 1
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && last_s1) |=> (byte_count_q == 16'd0 && !length_overflow_q))
		else $error("datagram state not cleared after last byte");

	// overflow only ever set with a saturated count
	a_ovf_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		length_overflow_q |-> (byte_count_q == 16'hFFFF))
		else $error("length overflow without saturated count");

	// any verdict other than bad length implies at least a full header
	a_len_vs_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_verdict_q != udprc_pkg::VERDICT_BAD_LENGTH))
		|-> (res_len_q >= 16'(udprc_pkg::UDP_HEADER_BYTES)))
		else $error("short datagram passed length check");

	// a finished datagram waiting in stage 2 is not lost while output stalls
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_adv) |=> (valid_s2 && $stable(count_s2)))
		else $error("stage 2 item dropped under stall");

	// the input side stays open whenever stage 1 is empty
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> rx.ready)
		else $error("input blocked with empty stage 1");
`endif

endmodule
`default_nettype wire
